FILE: rtl/core/psg_pkg.sv
// ----------------------------------------------------------------------------
// psg_pkg
// Shared constants, types and helpers for the PSG voice command encoder.
// ----------------------------------------------------------------------------
package psg_pkg;

   localparam int NumVoices  = 12;
   localparam int VoiceW     = 4;
   localparam int PeriodW    = 10;
   localparam int VolW       = 4;
   localparam int ChipW      = 2;
   localparam int ChanW      = 2;
   localparam int ByteW      = 8;
   localparam int NumOut     = 3;
   localparam int CountW     = 2;
   localparam int CacheIdxW  = (NumVoices > 1) ? $clog2(NumVoices) : 1;

   localparam logic [ByteW-1:0]   CmdAtten    = 8'h90;
   localparam logic [ByteW-1:0]   CmdTone     = 8'h80;
   localparam logic [VolW-1:0]    VolMax      = 4'hf;
   localparam logic [PeriodW-1:0] PeriodLoMsk = 10'h00f;
   localparam logic [PeriodW-1:0] PeriodHiMsk = 10'h3f0;

   localparam logic [CountW-1:0]  CountTone   = 2'd2;
   localparam logic [CountW-1:0]  CountFull   = 2'd3;

   typedef struct packed {
      logic            known;
      logic [VolW-1:0] vol;
   } cache_entry_type;

   typedef struct packed {
      logic [ChipW-1:0]             chip;
      logic [CountW-1:0]            count;
      logic [NumOut-1:0][ByteW-1:0] bytes;   // index 0 goes out first
      logic                         vol_write;
   } enc_result_type;

   typedef struct packed {
      logic can_load;
      logic busy;
   } queue_status_type;

   // Mirror a byte end for end (board wiring swaps bit 0 and bit 7 and so on).
   function automatic logic [ByteW-1:0] flip_byte(input logic [ByteW-1:0] v);
      logic [ByteW-1:0] r;
      for (int i = 0; i < ByteW; i++) begin
         r[i] = v[ByteW-1-i];
      end
      return r;
   endfunction

   // Chip number of a voice: three voices per chip.
   function automatic logic [ChipW-1:0] voice_chip(input logic [VoiceW-1:0] v);
      logic [ChipW-1:0] c;
      case (v)
         4'd0, 4'd1, 4'd2:   c = 2'd0;
         4'd3, 4'd4, 4'd5:   c = 2'd1;
         4'd6, 4'd7, 4'd8:   c = 2'd2;
         default:            c = 2'd3;
      endcase
      return c;
   endfunction

   // Channel on the chip: voice minus three times the chip number.
   function automatic logic [ChanW-1:0] voice_chan(input logic [VoiceW-1:0] v);
      logic [VoiceW-1:0] base;
      logic [VoiceW-1:0] diff;
      base = VoiceW'({voice_chip(v), 1'b0}) + VoiceW'(voice_chip(v));
      diff = v - base;
      return diff[ChanW-1:0];
   endfunction

endpackage

FILE: rtl/core/psg_vol_cache.sv
// ----------------------------------------------------------------------------
// psg_vol_cache
// Per-voice volume cache with valid bits; an unwritten entry reads unknown.
// ----------------------------------------------------------------------------
module psg_vol_cache
   import psg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [CacheIdxW-1:0] rd_idx,
   output cache_entry_type      rd_entry,
   input  logic                 wr_en,
   input  logic [CacheIdxW-1:0] wr_idx,
   input  logic [VolW-1:0]      wr_vol
);

   logic [NumVoices-1:0] valid_ff;
   logic [VolW-1:0]      vol_ff [NumVoices];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         vol_ff[wr_idx] <= wr_vol;
      end
   end

   // Guard the read so an out-of-range voice never indexes past the array.
   always_comb begin
      rd_entry = '0;
      if (int'(rd_idx) < NumVoices) begin
         rd_entry.known = valid_ff[rd_idx];
         rd_entry.vol   = vol_ff[rd_idx];
      end
   end

endmodule

FILE: rtl/core/psg_encoder.sv
// ----------------------------------------------------------------------------
// psg_encoder
// Builds the attenuation, tone latch and tone data bytes for one voice update.
// ----------------------------------------------------------------------------
module psg_encoder
   import psg_pkg::*;
(
   input  logic [VoiceW-1:0]  voice,
   input  logic [PeriodW-1:0] tone_period,
   input  logic [VolW-1:0]    volume,
   input  cache_entry_type    cached,
   output logic               in_range,
   output enc_result_type     result
);

   logic [ChanW-1:0]   chan;
   logic [ByteW-1:0]   atten_byte;
   logic [ByteW-1:0]   latch_byte;
   logic [ByteW-1:0]   data_byte;
   logic [PeriodW-1:0] period_lo;
   logic [PeriodW-1:0] period_hi;

   assign in_range  = int'(voice) < NumVoices;
   assign chan      = voice_chan(voice);
   assign period_lo = tone_period & PeriodLoMsk;
   assign period_hi = (tone_period & PeriodHiMsk) >> 4;

   assign atten_byte = CmdAtten | {1'b0, chan, 5'b0} | {4'b0, VolMax - volume};
   assign latch_byte = CmdTone | {1'b0, chan, 5'b0} | {4'b0, period_lo[3:0]};
   assign data_byte  = {2'b0, period_hi[5:0]};

   always_comb begin
      result.chip      = voice_chip(voice);
      result.vol_write = !(cached.known && (cached.vol == volume));
      if (result.vol_write) begin
         result.count    = CountFull;
         result.bytes[0] = flip_byte(atten_byte);
         result.bytes[1] = flip_byte(latch_byte);
         result.bytes[2] = flip_byte(data_byte);
      end else begin
         result.count    = CountTone;
         result.bytes[0] = flip_byte(latch_byte);
         result.bytes[1] = flip_byte(data_byte);
         result.bytes[2] = '0;
      end
   end

endmodule

FILE: rtl/core/psg_out_queue.sv
// ----------------------------------------------------------------------------
// psg_out_queue
// Result register holding the bytes of one update; drains one per transfer.
// ----------------------------------------------------------------------------
module psg_out_queue
   import psg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  enc_result_type   enc,
   output queue_status_type status,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [ChipW-1:0] rsp_chip_select,
   output logic [ByteW-1:0] rsp_command_byte,
   output logic             rsp_last
);

   logic [CountW-1:0]            num_ff, num_in;
   logic [ChipW-1:0]             chip_ff, chip_in;
   logic [NumOut-1:0][ByteW-1:0] bytes_ff, bytes_in;
   logic                         pop;

   assign pop = (num_ff != '0) && rsp_ready;

   assign status.can_load = (num_ff == '0) || ((num_ff == CountW'(1)) && rsp_ready);
   assign status.busy     = (num_ff != '0);

   always_comb begin
      num_in   = num_ff;
      chip_in  = chip_ff;
      bytes_in = bytes_ff;
      if (load) begin
         num_in   = enc.count;
         chip_in  = enc.chip;
         bytes_in = enc.bytes;
      end else if (pop) begin
         num_in   = num_ff - CountW'(1);
         for (int i = 0; i < NumOut - 1; i++) begin
            bytes_in[i] = bytes_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff <= '0;
      end else begin
         num_ff <= num_in;
      end
   end

   always_ff @(posedge clock) begin
      chip_ff  <= chip_in;
      bytes_ff <= bytes_in;
   end

   assign rsp_valid        = status.busy;
   assign rsp_chip_select  = chip_ff;
   assign rsp_command_byte = bytes_ff[0];
   assign rsp_last         = (num_ff == CountW'(1));

endmodule

FILE: rtl/core/psg_voice_command_encoder_unit.sv
// ----------------------------------------------------------------------------
// psg_voice_command_encoder_unit
// Turns voice updates into bit-reversed command bytes for four sound chips.
// ----------------------------------------------------------------------------
//
//   channel | direction | ports                                    | moves
//   --------+-----------+------------------------------------------+-------------
//   req     | in        | req_voice, req_tone_period, req_volume   | one update
//   rsp     | out       | rsp_chip_select, rsp_command_byte,       | one byte
//           |           | rsp_last                                 |
//
// An update waits in the input register while the encoder builds its bytes,
// then moves into the result register and leaves as two or three byte
// transfers, one per cycle while rsp is ready; the result register drains
// one byte per transfer. An update for a voice beyond the last is dropped
// with no bytes. Reset empties both registers and marks every cached volume
// unknown at once. A stall on rsp holds the result register and backs up
// into the input register; the next update is taken on the cycle the final
// byte of the previous one is transferred.
//
module psg_voice_command_encoder_unit
   import psg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [VoiceW-1:0]  req_voice,
   input  logic [PeriodW-1:0] req_tone_period,
   input  logic [VolW-1:0]    req_volume,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [ChipW-1:0]   rsp_chip_select,
   output logic [ByteW-1:0]   rsp_command_byte,
   output logic               rsp_last
);

   // Input register.
   logic               in_valid_ff;
   logic [VoiceW-1:0]  voice_ff;
   logic [PeriodW-1:0] period_ff;
   logic [VolW-1:0]    vol_ff;

   logic               in_range;
   logic               in_adv;
   logic               load;
   logic               req_xfer;
   cache_entry_type    cached;
   enc_result_type     enc;
   queue_status_type   qstat;

   // Advance the input register: drop an out-of-range voice outright, load an
   // in-range one once the result register frees up.
   assign load      = in_valid_ff && in_range && qstat.can_load;
   assign in_adv    = in_valid_ff && (!in_range || qstat.can_load);
   assign req_ready = !in_valid_ff || in_adv;
   assign req_xfer  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         voice_ff  <= req_voice;
         period_ff <= req_tone_period;
         vol_ff    <= req_volume;
      end
   end

   // Cache is written as the update moves into the result register, so the
   // next update read from the input register always sees it.
   psg_vol_cache u_cache (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (voice_ff[CacheIdxW-1:0]),
      .rd_entry (cached),
      .wr_en    (load && enc.vol_write),
      .wr_idx   (voice_ff[CacheIdxW-1:0]),
      .wr_vol   (vol_ff)
   );

   psg_encoder u_encoder (
      .voice       (voice_ff),
      .tone_period (period_ff),
      .volume      (vol_ff),
      .cached      (cached),
      .in_range    (in_range),
      .result      (enc)
   );

   psg_out_queue u_queue (
      .clock            (clock),
      .reset            (reset),
      .load             (load),
      .enc              (enc),
      .status           (qstat),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_chip_select  (rsp_chip_select),
      .rsp_command_byte (rsp_command_byte),
      .rsp_last         (rsp_last)
   );

   // A transfer that is not the final byte of an update leaves more to send.
   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> rsp_valid)
      else $error("byte stream ended before last");

   // A dropped voice never stalls the input side.
   a_drop_no_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !in_range) |-> req_ready)
      else $error("out-of-range voice stalled input");

   // A load always starts a fresh update of two or three bytes.
   a_load_fresh: assert property (@(posedge clock) disable iff (reset)
      load |=> (rsp_valid && !rsp_last))
      else $error("loaded update too short");

   // The chip port stays fixed across the bytes of one update.
   a_chip_steady: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> $stable(rsp_chip_select))
      else $error("chip select changed inside an update");

endmodule
